// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the assertion file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uds_pkg.sv -----
// ---------------------------------------------------------------------------
// UDS responder package
// Service codes, response constants and the decoded command item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uds_pkg;

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [31:0] SEED_RESET  = 32'd1188819384;
    localparam logic [15:0] DID_RESET   = 16'h0123;
    localparam logic [15:0] ECU_ID_RESET = 16'h0078;

    localparam logic [7:0] SID_READ     = 8'h22;
    localparam logic [7:0] SID_SEC      = 8'h27;
    localparam logic [7:0] SID_WRITE    = 8'h2E;
    localparam logic [7:0] SID_NEG      = 8'h7F;
    localparam logic [7:0] SID_READ_POS = 8'h62;
    localparam logic [7:0] SID_SEC_POS  = 8'h67;
    localparam logic [7:0] SID_WRITE_POS = 8'h6E;

    localparam logic [7:0] NRC_BAD_LEN  = 8'h13;
    localparam logic [7:0] NRC_RANGE    = 8'h31;
    localparam logic [7:0] NRC_DENIED   = 8'h33;
    localparam logic [7:0] NRC_BAD_KEY  = 8'h35;

    localparam logic [7:0] SUB_SEED     = 8'h01;
    localparam logic [7:0] SUB_KEY      = 8'h02;
    localparam logic [7:0] PAD          = 8'h55;

    localparam logic [3:0] LEN_READ     = 4'd3;
    localparam logic [3:0] LEN_SEC_S    = 4'd2;
    localparam logic [3:0] LEN_SEC_L    = 4'd6;
    localparam logic [3:0] LEN_WRITE    = 4'd5;

    localparam logic [7:0] TXL_NEG      = 8'h03;
    localparam logic [7:0] TXL_READ     = 8'h05;
    localparam logic [7:0] TXL_SEED     = 8'h06;
    localparam logic [7:0] TXL_KEY      = 8'h02;
    localparam logic [7:0] TXL_WRITE    = 8'h03;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED = 1'b0,
        CFG_DID  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_IGN,
        CMD_READ,
        CMD_FIXED,
        CMD_SEED,
        CMD_KEY,
        CMD_RESEND,
        CMD_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [63:0] frame;
        logic        hit;
        logic [15:0] new_id;
    } cmd_t;

    function automatic logic [63:0] neg_frame(input logic [7:0] sid, input logic [7:0] nrc);
        return {TXL_NEG, SID_NEG, sid, nrc, PAD, PAD, PAD, PAD};
    endfunction

endpackage

// ----- rtl/uds_single_frame_responder.sv -----
// ---------------------------------------------------------------------------
// UDS single-frame responder
// Answers read, security access and write services on CAN single frames.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  operation, rx_byte0..rx_byte7
// out       source     out_valid / out_stall response_can_id, tx_byte0..tx_byte7
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low; a response passes the
// decode and queue write at the accepting edge, then the back-end output
// register.
// in_stall rises only when the command queue is full, i.e. out_stall has held.
// Reset sets state and configuration to defaults; cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uds_single_frame_responder
#(
    parameter int QUEUE_DEPTH = uds_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [7:0]                     rx_byte0,
    input  logic [7:0]                     rx_byte1,
    input  logic [7:0]                     rx_byte2,
    input  logic [7:0]                     rx_byte3,
    input  logic [7:0]                     rx_byte4,
    input  logic [7:0]                     rx_byte5,
    input  logic [7:0]                     rx_byte6,
    input  logic [7:0]                     rx_byte7,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    response_can_id,
    output logic [7:0]                     tx_byte0,
    output logic [7:0]                     tx_byte1,
    output logic [7:0]                     tx_byte2,
    output logic [7:0]                     tx_byte3,
    output logic [7:0]                     tx_byte4,
    output logic [7:0]                     tx_byte5,
    output logic [7:0]                     tx_byte6,
    output logic [7:0]                     tx_byte7
);
    import uds_pkg::*;

    logic pad_unused;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_valid;
    cmd_t wr_cmd;
    cmd_t head;

    // padding byte carries nothing
    assign pad_unused = ^rx_byte7;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;

    uds_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .operation  (operation),
        .rx_byte0   (rx_byte0),
        .rx_byte1   (rx_byte1),
        .rx_byte2   (rx_byte2),
        .rx_byte3   (rx_byte3),
        .rx_byte4   (rx_byte4),
        .rx_byte5   (rx_byte5),
        .rx_byte6   (rx_byte6),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (wr_cmd)
    );

    uds_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (wr_cmd),
        .pop       (pop),
        .rd_cmd    (head),
        .not_empty (queue_valid),
        .full      (queue_full)
    );

    uds_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (queue_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .response_can_id (response_can_id),
        .tx_byte0        (tx_byte0),
        .tx_byte1        (tx_byte1),
        .tx_byte2        (tx_byte2),
        .tx_byte3        (tx_byte3),
        .tx_byte4        (tx_byte4),
        .tx_byte5        (tx_byte5),
        .tx_byte6        (tx_byte6),
        .tx_byte7        (tx_byte7)
    );

endmodule

// ----- rtl/uds_front.sv -----
// ---------------------------------------------------------------------------
// UDS front end
// Holds configuration, decodes request frames into command items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uds_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [uds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           operation,
    input  logic [7:0]                     rx_byte0,
    input  logic [7:0]                     rx_byte1,
    input  logic [7:0]                     rx_byte2,
    input  logic [7:0]                     rx_byte3,
    input  logic [7:0]                     rx_byte4,
    input  logic [7:0]                     rx_byte5,
    input  logic [7:0]                     rx_byte6,
    input  logic                           queue_full,
    output logic                           push,
    output uds_pkg::cmd_t                  cmd
);
    import uds_pkg::*;

    logic [31:0] seed_reg;
    logic [15:0] did_reg;
    logic [3:0]  len;
    logic        known;
    logic        did_ok;
    logic        key_ok;
    logic [7:0]  s0, s1, s2, s3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            did_reg  <= DID_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEED: seed_reg <= cfg_data;
                CFG_DID:  did_reg  <= cfg_data[15:0];
            endcase
        end
    end

    assign s0 = seed_reg[31:24];
    assign s1 = seed_reg[23:16];
    assign s2 = seed_reg[15:8];
    assign s3 = seed_reg[7:0];

    assign len    = rx_byte0[3:0];
    assign did_ok = ({rx_byte2, rx_byte3} == did_reg);
    assign key_ok = ((s0 ^ s1) == rx_byte3) && (8'(s1 + s2) == rx_byte4)
                 && ((s2 ^ s3) == rx_byte5) && (8'(s3 + s0) == rx_byte6);

    always_comb
    begin
        cmd.kind   = CMD_FIXED;
        cmd.frame  = '0;
        cmd.hit    = 1'b0;
        cmd.new_id = {rx_byte4, rx_byte5};
        known      = 1'b1;
        if (operation)
        begin
            cmd.kind = CMD_IGN;
        end
        else
        begin
            unique case (rx_byte1)
                SID_READ:
                begin
                    if (len != LEN_READ)
                        cmd.frame = neg_frame(SID_READ, NRC_BAD_LEN);
                    else if (did_ok)
                    begin
                        cmd.kind  = CMD_READ;
                        cmd.frame = {TXL_READ, SID_READ_POS, did_reg, 16'h0000, PAD, PAD};
                    end
                    else
                        cmd.frame = neg_frame(SID_READ, NRC_RANGE);
                end
                SID_SEC:
                begin
                    if (len != LEN_SEC_S && len != LEN_SEC_L)
                        cmd.frame = neg_frame(SID_SEC, NRC_BAD_LEN);
                    else if (len == LEN_SEC_S && rx_byte2 == SUB_SEED)
                    begin
                        cmd.kind  = CMD_SEED;
                        cmd.frame = {TXL_SEED, SID_SEC_POS, SUB_SEED, seed_reg, PAD};
                    end
                    else if (rx_byte2 == SUB_KEY)
                    begin
                        cmd.kind  = CMD_KEY;
                        cmd.hit   = key_ok;
                        cmd.frame = key_ok
                            ? {TXL_KEY, SID_SEC_POS, SUB_KEY, PAD, PAD, PAD, PAD, PAD}
                            : neg_frame(SID_SEC, NRC_BAD_KEY);
                    end
                    else
                        cmd.kind = CMD_RESEND;
                end
                SID_WRITE:
                begin
                    cmd.kind = CMD_WRITE;
                    if (len != LEN_WRITE)
                        cmd.frame = neg_frame(SID_WRITE, NRC_BAD_LEN);
                    else if (did_ok)
                    begin
                        cmd.hit   = 1'b1;
                        cmd.frame = {TXL_WRITE, SID_WRITE_POS, did_reg, PAD, PAD, PAD, PAD};
                    end
                    else
                        cmd.frame = neg_frame(SID_WRITE, NRC_RANGE);
                end
                default: known = 1'b0;
            endcase
            if (rx_byte0[7:4] != 4'h0)
                known = 1'b0;
        end
    end

    assign push = in_valid && !queue_full && known;

endmodule

// ----- rtl/uds_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// UDS command queue
// Short queue of decoded command items between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uds_cmd_fifo
#(
    parameter int DEPTH = uds_pkg::QUEUE_DEPTH   // 2 or more
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uds_pkg::cmd_t wr_cmd,
    input  logic          pop,
    output uds_pkg::cmd_t rd_cmd,
    output logic          not_empty,
    output logic          full
);
    import uds_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    assign rd_cmd    = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

// ----- rtl/uds_back.sv -----
// ---------------------------------------------------------------------------
// UDS back end
// Session state, identifier handling and the response output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uds_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  uds_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [15:0]   response_can_id,
    output logic [7:0]    tx_byte0,
    output logic [7:0]    tx_byte1,
    output logic [7:0]    tx_byte2,
    output logic [7:0]    tx_byte3,
    output logic [7:0]    tx_byte4,
    output logic [7:0]    tx_byte5,
    output logic [7:0]    tx_byte6,
    output logic [7:0]    tx_byte7
);
    import uds_pkg::*;

    logic        seed_issued_reg, seed_issued_next;
    logic        unlocked_reg, unlocked_next;
    logic [15:0] cur_id_reg, cur_id_next;
    logic [15:0] staged_id_reg, staged_id_next;
    logic [63:0] last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] can_id_reg;
    logic [63:0] frame_reg;
    logic [63:0] resp;
    logic        issue;
    logic        emit;

    assign issue = head_valid && (!out_valid_reg || !out_stall);
    assign pop   = issue;

    always_comb
    begin
        resp             = head.frame;
        emit             = 1'b1;
        seed_issued_next = seed_issued_reg;
        unlocked_next    = unlocked_reg;
        cur_id_next      = cur_id_reg;
        staged_id_next   = staged_id_reg;
        unique case (head.kind)
            CMD_IGN:
            begin
                emit        = 1'b0;
                cur_id_next = staged_id_reg;
            end
            CMD_READ:   resp = {head.frame[63:32], cur_id_reg, head.frame[15:0]};
            CMD_FIXED:  ;
            CMD_SEED:   seed_issued_next = 1'b1;
            CMD_KEY:
            begin
                if (!seed_issued_reg)
                    resp = last_reg;
                else if (head.hit)
                    unlocked_next = 1'b1;
            end
            CMD_RESEND: resp = last_reg;
            CMD_WRITE:
            begin
                if (!unlocked_reg)
                    resp = neg_frame(SID_WRITE, NRC_DENIED);
                else if (head.hit)
                    staged_id_next = head.new_id;
            end
            default:    emit = 1'b0;
        endcase
        if (!issue)
        begin
            emit             = 1'b0;
            seed_issued_next = seed_issued_reg;
            unlocked_next    = unlocked_reg;
            cur_id_next      = cur_id_reg;
            staged_id_next   = staged_id_reg;
        end
        last_next      = emit ? resp : last_reg;
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_issued_reg <= 1'b0;
            unlocked_reg    <= 1'b0;
            cur_id_reg      <= ECU_ID_RESET;
            staged_id_reg   <= ECU_ID_RESET;
            last_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seed_issued_reg <= seed_issued_next;
            unlocked_reg    <= unlocked_next;
            cur_id_reg      <= cur_id_next;
            staged_id_reg   <= staged_id_next;
            last_reg        <= last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            can_id_reg <= cur_id_reg;
            frame_reg  <= resp;
        end
    end

    assign out_valid       = out_valid_reg;
    assign response_can_id = can_id_reg;
    assign tx_byte0        = frame_reg[63:56];
    assign tx_byte1        = frame_reg[55:48];
    assign tx_byte2        = frame_reg[47:40];
    assign tx_byte3        = frame_reg[39:32];
    assign tx_byte4        = frame_reg[31:24];
    assign tx_byte5        = frame_reg[23:16];
    assign tx_byte6        = frame_reg[15:8];
    assign tx_byte7        = frame_reg[7:0];

endmodule

// ----- rtl/uds_checker.sv -----
// ---------------------------------------------------------------------------
// UDS responder checker
// Port-level properties of the responder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uds_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_ready,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [15:0]                    response_can_id,
    input logic [7:0]                     tx_byte0,
    input logic [7:0]                     tx_byte1,
    input logic [7:0]                     tx_byte2,
    input logic [7:0]                     tx_byte7
);
    import uds_pkg::*;

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_byte1) && $stable(response_can_id), "stalled response changed")
    `ASSERT_IMPLY(a_neg_len, out_valid && tx_byte1 == SID_NEG, tx_byte0 == TXL_NEG && tx_byte7 == PAD, "negative response badly framed")
    `ASSERT_IMPLY(a_neg_sid, out_valid && tx_byte1 == SID_NEG, tx_byte2 == SID_READ || tx_byte2 == SID_SEC || tx_byte2 == SID_WRITE, "negative response for unknown service")
    `ASSERT_IMPLY(a_cfg_ready, 1'b1, cfg_ready, "register port not ready")

endmodule

bind uds_single_frame_responder uds_checker u_checker (.*);

// ----- tb/sv/uds_response_checker.sv -----
// ---------------------------------------------------------------------------
// UDS responder checker
// Watches the request, response and register channels of the responder,
// predicts each response frame from its own copy of the service state and
// compares every accepted response, field by field, with the oldest
// prediction still outstanding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uds_response_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [uds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           operation,
    input  logic [7:0]                     rx_byte0,
    input  logic [7:0]                     rx_byte1,
    input  logic [7:0]                     rx_byte2,
    input  logic [7:0]                     rx_byte3,
    input  logic [7:0]                     rx_byte4,
    input  logic [7:0]                     rx_byte5,
    input  logic [7:0]                     rx_byte6,
    input  logic [7:0]                     rx_byte7,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [15:0]                    response_can_id,
    input  logic [7:0]                     tx_byte0,
    input  logic [7:0]                     tx_byte1,
    input  logic [7:0]                     tx_byte2,
    input  logic [7:0]                     tx_byte3,
    input  logic [7:0]                     tx_byte4,
    input  logic [7:0]                     tx_byte5,
    input  logic [7:0]                     tx_byte6,
    input  logic [7:0]                     tx_byte7,
    output int                             fail_count,
    output int                             outstanding,
    output int                             responses_seen
);
    import uds_pkg::*;

    typedef struct packed {
        logic [15:0] can_id;
        logic [63:0] frame;
    } response_t;

    response_t   expected_responses[$];

    logic [31:0] seed_reg;
    logic [15:0] did_reg;
    logic        seed_sent;
    logic        sec_unlocked;
    logic [15:0] ecu_id_now;
    logic [15:0] ecu_id_staged;
    logic [63:0] prev_frame;

    function automatic logic [63:0] reject(input logic [7:0] sid, input logic [7:0] nrc);
        return {TXL_NEG, SID_NEG, sid, nrc, PAD, PAD, PAD, PAD};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic compute_response(input logic op, input logic [63:0] rx);
        logic [63:0] f;
        logic [3:0]  len;
        logic [7:0]  sid;
        logic [7:0]  sub;
        logic [15:0] did;
        logic [31:0] key;
        logic        produce;
        response_t   r;
        f       = '0;
        produce = 1'b1;
        len     = rx[59:56];
        sid     = rx[55:48];
        sub     = rx[47:40];
        did     = rx[47:32];
        key     = {seed_reg[31:24] ^ seed_reg[23:16], seed_reg[23:16] + seed_reg[15:8],
                   seed_reg[15:8] ^ seed_reg[7:0], seed_reg[7:0] + seed_reg[31:24]};
        if (op)
        begin
            ecu_id_now = ecu_id_staged;
            produce    = 1'b0;
        end
        else if (rx[63:60] != 4'h0)
        begin
            produce = 1'b0;
        end
        else if (sid == SID_READ)
        begin
            if (len != LEN_READ)
                f = reject(SID_READ, NRC_BAD_LEN);
            else if (did == did_reg)
                f = {TXL_READ, SID_READ_POS, did_reg, ecu_id_now, PAD, PAD};
            else
                f = reject(SID_READ, NRC_RANGE);
        end
        else if (sid == SID_SEC)
        begin
            if (len != LEN_SEC_S && len != LEN_SEC_L)
                f = reject(SID_SEC, NRC_BAD_LEN);
            else if (len == LEN_SEC_S && sub == SUB_SEED)
            begin
                f         = {TXL_SEED, SID_SEC_POS, SUB_SEED, seed_reg, PAD};
                seed_sent = 1'b1;
            end
            else if (sub == SUB_KEY && seed_sent)
            begin
                if (rx[39:8] == key)
                begin
                    f            = {TXL_KEY, SID_SEC_POS, SUB_KEY, PAD, PAD, PAD, PAD, PAD};
                    sec_unlocked = 1'b1;
                end
                else
                    f = reject(SID_SEC, NRC_BAD_KEY);
            end
            else
                f = prev_frame;
        end
        else if (sid == SID_WRITE)
        begin
            if (!sec_unlocked)
                f = reject(SID_WRITE, NRC_DENIED);
            else if (len != LEN_WRITE)
                f = reject(SID_WRITE, NRC_BAD_LEN);
            else if (did == did_reg)
            begin
                f             = {TXL_WRITE, SID_WRITE_POS, did_reg, PAD, PAD, PAD, PAD};
                ecu_id_staged = rx[31:16];
            end
            else
                f = reject(SID_WRITE, NRC_RANGE);
        end
        else
        begin
            produce = 1'b0;
        end
        if (produce)
        begin
            prev_frame = f;
            r.can_id   = ecu_id_now;
            r.frame    = f;
            expected_responses.push_back(r);
        end
    endtask

    task automatic check_response();
        response_t   want;
        logic [63:0] got;
        int          i;
        got = {tx_byte0, tx_byte1, tx_byte2, tx_byte3, tx_byte4, tx_byte5, tx_byte6, tx_byte7};
        responses_seen++;
        if (expected_responses.size() == 0)
        begin
            report_mismatch("response with none outstanding", got, 64'h0);
        end
        else
        begin
            want = expected_responses.pop_front();
            if (response_can_id != want.can_id)
                report_mismatch("response_can_id", 64'(response_can_id), 64'(want.can_id));
            for (i = 0; i < 8; i++)
            begin
                if (got[63-8*i -: 8] != want.frame[63-8*i -: 8])
                    report_mismatch($sformatf("tx_byte%0d", i), 64'(got[63-8*i -: 8]),
                                    64'(want.frame[63-8*i -: 8]));
            end
        end
    endtask

    initial
    begin
        fail_count     = 0;
        outstanding    = 0;
        responses_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      = SEED_RESET;
            did_reg       = DID_RESET;
            seed_sent     = 1'b0;
            sec_unlocked  = 1'b0;
            ecu_id_now    = ECU_ID_RESET;
            ecu_id_staged = ECU_ID_RESET;
            prev_frame    = '0;
            expected_responses.delete();
            outstanding   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_response();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SEED)
                    seed_reg = cfg_data;
                else if (cfg_index == CFG_DID)
                    did_reg = cfg_data[15:0];
            end
            if (in_valid && !in_stall)
                compute_response(operation, {rx_byte0, rx_byte1, rx_byte2, rx_byte3,
                                             rx_byte4, rx_byte5, rx_byte6, rx_byte7});
            outstanding = expected_responses.size();
        end
    end

endmodule

// ----- tb/sv/tb_uds_single_frame_responder.sv -----
// ---------------------------------------------------------------------------
// UDS single-frame responder testbench
// Drives a directed set of read, security access, write and ignition items,
// then random, mostly well-formed service sequences under several register
// settings, with bursty input, patterned output stalls and one long output
// hold-off. The checker beside the block predicts and compares responses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uds_single_frame_responder;
    import uds_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 85;
    localparam int          NUM_SETTINGS = 5;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          SETTLE       = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [7:0]            rx_byte0, rx_byte1, rx_byte2, rx_byte3;
    logic [7:0]            rx_byte4, rx_byte5, rx_byte6, rx_byte7;
    logic                  out_valid;
    logic                  out_stall;
    logic [15:0]           response_can_id;
    logic [7:0]            tx_byte0, tx_byte1, tx_byte2, tx_byte3;
    logic [7:0]            tx_byte4, tx_byte5, tx_byte6, tx_byte7;

    int                    fail_count;
    int                    outstanding;
    int                    responses_seen;

    int unsigned           cycle_count = 0;
    int                    burst_left = 0;
    int                    frames_sent = 0;
    int                    ignitions_sent = 0;
    bit                    hold_request = 1'b0;
    logic [31:0]           cur_seed = SEED_RESET;
    logic [15:0]           cur_did = DID_RESET;

    uds_single_frame_responder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .rx_byte0        (rx_byte0),
        .rx_byte1        (rx_byte1),
        .rx_byte2        (rx_byte2),
        .rx_byte3        (rx_byte3),
        .rx_byte4        (rx_byte4),
        .rx_byte5        (rx_byte5),
        .rx_byte6        (rx_byte6),
        .rx_byte7        (rx_byte7),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .response_can_id (response_can_id),
        .tx_byte0        (tx_byte0),
        .tx_byte1        (tx_byte1),
        .tx_byte2        (tx_byte2),
        .tx_byte3        (tx_byte3),
        .tx_byte4        (tx_byte4),
        .tx_byte5        (tx_byte5),
        .tx_byte6        (tx_byte6),
        .tx_byte7        (tx_byte7)
    );

    uds_response_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .rx_byte0        (rx_byte0),
        .rx_byte1        (rx_byte1),
        .rx_byte2        (rx_byte2),
        .rx_byte3        (rx_byte3),
        .rx_byte4        (rx_byte4),
        .rx_byte5        (rx_byte5),
        .rx_byte6        (rx_byte6),
        .rx_byte7        (rx_byte7),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .response_can_id (response_can_id),
        .tx_byte0        (tx_byte0),
        .tx_byte1        (tx_byte1),
        .tx_byte2        (tx_byte2),
        .tx_byte3        (tx_byte3),
        .tx_byte4        (tx_byte4),
        .tx_byte5        (tx_byte5),
        .tx_byte6        (tx_byte6),
        .tx_byte7        (tx_byte7),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .responses_seen  (responses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: stall pattern in modes, plus a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    function automatic logic [31:0] sec_key(input logic [31:0] seed);
        return {seed[31:24] ^ seed[23:16], seed[23:16] + seed[15:8],
                seed[15:8] ^ seed[7:0], seed[7:0] + seed[31:24]};
    endfunction

    task automatic send_frame(input logic op, input logic [63:0] data);
        bit take;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(15, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte0  <= data[63:56];
        rx_byte1  <= data[55:48];
        rx_byte2  <= data[47:40];
        rx_byte3  <= data[39:32];
        rx_byte4  <= data[31:24];
        rx_byte5  <= data[23:16];
        rx_byte6  <= data[15:8];
        rx_byte7  <= data[7:0];
        do
        begin
            @(negedge clk);
            take = !in_stall;
            @(posedge clk);
        end
        while (!take);
        if (op)
            ignitions_sent++;
        else
            frames_sent++;
    endtask

    // wait until every response has come, then let the block settle
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        bit take;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            take = cfg_ready;
            @(posedge clk);
        end
        while (!take);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic make_random_item(output logic op, output logic [63:0] data,
                                    output bit ignored);
        int unsigned kind;
        logic [7:0]  sid;
        kind = $urandom_range(0, 99);
        op   = 1'b0;
        data = {$urandom, $urandom};
        if (kind < 14)
        begin
            data[63:56] = {4'h0, LEN_READ};
            data[55:48] = SID_READ;
            data[47:32] = cur_did;
        end
        else if (kind < 18)
        begin
            data[63:60] = 4'h0;
            data[55:48] = SID_READ;
            if ($urandom_range(0, 1))
                data[47:32] = cur_did;
        end
        else if (kind < 32)
        begin
            data[63:56] = {4'h0, LEN_SEC_S};
            data[55:48] = SID_SEC;
            data[47:40] = SUB_SEED;
        end
        else if (kind < 52)
        begin
            data[63:56] = {4'h0, ($urandom_range(0, 1) ? LEN_SEC_S : LEN_SEC_L)};
            data[55:48] = SID_SEC;
            data[47:40] = SUB_KEY;
            data[39:8]  = sec_key(cur_seed);
            if (kind >= 46)
                data[39:8] = data[39:8] ^ (32'h1 << $urandom_range(0, 31));
        end
        else if (kind < 66)
        begin
            data[63:56] = {4'h0, LEN_WRITE};
            data[55:48] = SID_WRITE;
            data[47:32] = cur_did;
        end
        else if (kind < 72)
        begin
            data[63:60] = 4'h0;
            data[55:48] = SID_WRITE;
            if ($urandom_range(0, 1))
                data[47:32] = cur_did;
        end
        else if (kind < 80)
        begin
            op = 1'b1;
        end
        else if (kind < 86)
        begin
            data[63:60] = 4'h0;
            data[55:48] = SID_SEC;
            if ($urandom_range(0, 1))
                data[59:56] = $urandom_range(0, 1) ? LEN_SEC_S : LEN_SEC_L;
        end
        else if ($urandom_range(0, 1))
        begin
            data[63:60] = 4'h0;
        end
        sid     = data[55:48];
        ignored = !op && (data[63:60] != 4'h0 ||
                          !(sid == SID_READ || sid == SID_SEC || sid == SID_WRITE));
    endtask

    initial
    begin
        logic [31:0] seeds [NUM_SETTINGS];
        logic [15:0] dids  [NUM_SETTINGS];
        logic [31:0] k;
        logic        op;
        logic [63:0] data;
        bit          ignored;
        int          counted;
        int          p;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEED;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = 1'b0;
        rx_byte0  = '0;
        rx_byte1  = '0;
        rx_byte2  = '0;
        rx_byte3  = '0;
        rx_byte4  = '0;
        rx_byte5  = '0;
        rx_byte6  = '0;
        rx_byte7  = '0;

        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, SEED_RESET};
        dids  = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), DID_RESET};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        k = sec_key(SEED_RESET);
        // key with no seed issued before any response: all-zero resend
        send_frame(1'b0, {4'h0, LEN_SEC_S, SID_SEC, SUB_KEY, 40'h0});
        send_frame(1'b0, {4'h0, LEN_READ, SID_READ, DID_RESET, 32'hFFFF_FFFF});
        send_frame(1'b0, {8'h00, SID_READ, DID_RESET, 32'h0});
        send_frame(1'b0, {8'h0F, SID_READ, DID_RESET, 32'h0});
        send_frame(1'b0, {4'h0, LEN_READ, SID_READ, ~DID_RESET, 32'h0});
        send_frame(1'b0, {4'h0, LEN_WRITE, SID_WRITE, DID_RESET, 16'h1234, 16'h0});
        send_frame(1'b0, {8'h04, SID_SEC, SUB_SEED, 40'h0});
        send_frame(1'b0, {4'h0, LEN_SEC_L, SID_SEC, SUB_KEY, k, 8'h00});
        send_frame(1'b0, {4'h0, LEN_SEC_S, SID_SEC, SUB_SEED, 40'hFF_FFFF_FFFF});
        send_frame(1'b0, {4'h0, LEN_SEC_L, SID_SEC, SUB_SEED, 40'h0});
        send_frame(1'b0, {4'h0, LEN_SEC_S, SID_SEC, 8'h00, 40'h0});
        send_frame(1'b0, {4'h0, LEN_SEC_L, SID_SEC, SUB_KEY, k ^ 32'h1, 8'h00});
        send_frame(1'b0, {4'h0, LEN_WRITE, SID_WRITE, DID_RESET, 16'h1234, 16'h0});
        send_frame(1'b0, {4'h0, LEN_SEC_S, SID_SEC, SUB_KEY, k, 8'hAA});
        send_frame(1'b0, {4'h0, LEN_SEC_L, SID_SEC, SUB_KEY, k, 8'hFF});
        send_frame(1'b0, {8'h04, SID_WRITE, DID_RESET, 16'hBEEF, 16'h0});
        send_frame(1'b0, {4'h0, LEN_WRITE, SID_WRITE, DID_RESET ^ 16'h8000, 16'hBEEF, 16'h0});
        send_frame(1'b0, {4'h0, LEN_WRITE, SID_WRITE, DID_RESET, 16'hFFFF, 16'h0});
        send_frame(1'b0, {4'h0, LEN_READ, SID_READ, DID_RESET, 32'h0});
        send_frame(1'b1, 64'h0);
        send_frame(1'b0, {4'h0, LEN_READ, SID_READ, DID_RESET, 32'h0});
        send_frame(1'b0, {8'hF3, SID_READ, DID_RESET, 32'h0});
        send_frame(1'b0, {4'h0, LEN_READ, 8'hFF, DID_RESET, 32'h0});
        send_frame(1'b0, {4'h0, LEN_WRITE, SID_WRITE, DID_RESET, 16'h0000, 16'hFFFF});
        send_frame(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(1'b0, {4'h0, LEN_READ, SID_READ, DID_RESET, 32'h0});
        drain_and_settle();

        // random part, one register setting per phase
        for (p = 0; p < NUM_SETTINGS; p++)
        begin
            write_reg(CFG_SEED, seeds[p]);
            write_reg(CFG_DID, {16'h0, dids[p]});
            cur_seed = seeds[p];
            cur_did  = dids[p];
            counted  = 0;
            while (counted < PHASE_ITEMS)
            begin
                if (p == 2 && counted == 30)
                    hold_request = 1'b1;
                if (p == 3 && counted == 50)
                    drain_and_settle();
                make_random_item(op, data, ignored);
                send_frame(op, data);
                if (!ignored)
                    counted++;
            end
            drain_and_settle();
        end

        $display("Covered %0d frames and %0d ignition items over %0d register settings,",
                 frames_sent, ignitions_sent, NUM_SETTINGS + 1);
        $display("with bursty input, patterned output stalls and a long hold-off; %0d responses checked.",
                 responses_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
